[design/mersenne_twister_generator_defines.svh]
// Assertion macros for the Mersenne twister generator.
// Standalone header: no package or module dependencies.
`ifndef MERSENNE_TWISTER_GENERATOR_DEFINES_SVH
`define MERSENNE_TWISTER_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define MTG_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication; the consequent may be a sequence.
`define MTG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
		else $error(msg);

`endif

[design/mtg_pkg.sv]
// Shared constants, types and the tempering function of the Mersenne twister generator.
// No dependencies.
`timescale 1ns / 1ps

package mtg_pkg;

	localparam int MT_WORDS = 624;
	localparam int MT_SHIFT = 397;
	localparam int WORD_W   = 32;
	localparam int IDX_W    = $clog2(MT_WORDS);

	localparam logic [WORD_W-1:0] MT_MATRIX   = 32'd2567483615;
	localparam logic [WORD_W-1:0] MT_MASK_B   = 32'd2636928640;
	localparam logic [WORD_W-1:0] MT_MASK_C   = 32'd4022730752;
	localparam logic [WORD_W-1:0] MT_UPPER    = 32'h8000_0000;
	localparam logic [WORD_W-1:0] MT_LOWER    = 32'h7fff_ffff;
	localparam logic [WORD_W-1:0] MT_FILL_MUL = 32'd69069;

	// Write port and two read ports of the state table.
	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [WORD_W-1:0] wdata;
		logic [IDX_W-1:0]  raddr_a;
		logic [IDX_W-1:0]  raddr_b;
	} mtg_ram_req_t;

	function automatic logic [WORD_W-1:0] mt_temper(input logic [WORD_W-1:0] y_in);
		logic [WORD_W-1:0] y;
		y = y_in;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & MT_MASK_B);
		y = y ^ ((y << 15) & MT_MASK_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

[design/mtg_ram.sv]
// State table of the Mersenne twister generator: one write port, two registered read ports.
// Depends on mtg_pkg.
`timescale 1ns / 1ps

module mtg_ram (
	input  logic                         clk,
	input  mtg_pkg::mtg_ram_req_t        req,
	output logic [mtg_pkg::WORD_W-1:0]   rd_a,
	output logic [mtg_pkg::WORD_W-1:0]   rd_b
);
	import mtg_pkg::*;

	logic [WORD_W-1:0] mem [MT_WORDS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		rd_a <= mem[req.raddr_a];
		rd_b <= mem[req.raddr_b];
	end

endmodule

[design/mersenne_twister_generator.sv]
// Top level of the Mersenne twister generator: control sequencer around the state table.
// Depends on mtg_pkg, mtg_ram and mersenne_twister_generator_defines.svh.
`timescale 1ns / 1ps
`include "mersenne_twister_generator_defines.svh"

// Usage
//   Command channel: an item (mode, seed_value) is taken at a rising edge with start high
//   and busy low. Result channel: done is high for exactly one cycle with value and
//   is_number; the receiver must take it then, it cannot hold the block off.
//   mode 0 draws a tempered word (is_number = 1). mode 1 refills the 624-word table from
//   the seed with x*69069+1 and twists it; mode 2 twists only (filling first if the table
//   was never filled). A nonzero seed_value replaces the stored seed for modes 1 and 2.
//   mode 3 does nothing. Modes 1..3 answer with value 0 and is_number 0.
// Sequencing (accept edge to the edge that takes the result)
//   draw: one table read plus tempering; the next item is taken on the result edge.
//   twist: one read-modify-write per word, plus a preload and a drain step.
//   fill: one word written per cycle by the seeding multiplier.
// Reset
//   arst_n clears the read index, the filled flag and the stored seed; the table itself
//   holds garbage until the first fill, which always runs before any word is read.
module mersenne_twister_generator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   mode,
	input  logic [mtg_pkg::WORD_W-1:0]   seed_value,
	output logic                         done,
	output logic [mtg_pkg::WORD_W-1:0]   value,
	output logic                         is_number
);
	import mtg_pkg::*;

	localparam logic [1:0] MODE_DRAW  = 2'd0;
	localparam logic [1:0] MODE_SEED  = 2'd1;
	localparam logic [1:0] MODE_TWIST = 2'd2;

	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(MT_WORDS - 1);
	localparam logic [IDX_W-1:0] SHIFT_IDX = IDX_W'(MT_SHIFT);
	localparam logic [IDX_W-1:0] FAR_SPLIT = IDX_W'(MT_WORDS - MT_SHIFT);
	localparam logic [IDX_W-1:0] IDX_ONE   = IDX_W'(1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_TW_PRE,
		ST_TW_RUN,
		ST_TW_DRAIN,
		ST_DRAW_RD,
		ST_DRAW_TEMP
	} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  read_idx_q;   // next word to hand out
	logic              filled_q;
	logic [WORD_W-1:0] seed_q;
	logic [IDX_W-1:0]  k_q;          // fill / twist word counter
	logic [WORD_W-1:0] fill_x_q;     // seeding recurrence value
	logic [WORD_W-1:0] cur_q;        // old value of the word being twisted
	logic              op_draw_q;    // pending item is a draw
	logic              tw_v_s1;
	logic [IDX_W-1:0]  tw_idx_s1;
	logic              done_q;
	logic [WORD_W-1:0] value_q;
	logic              is_number_q;

	mtg_ram_req_t      ram_req;
	logic [WORD_W-1:0] rd_a;
	logic [WORD_W-1:0] rd_b;

	logic              accept;
	logic [WORD_W-1:0] seed_eff;
	logic [WORD_W-1:0] tw_y;
	logic [WORD_W-1:0] tw_w;
	logic [IDX_W-1:0]  k_nxt;
	logic [IDX_W-1:0]  k_far;

	assign accept   = start && (state_q == ST_IDLE);
	assign seed_eff = (seed_value != '0) ? seed_value : seed_q;

	// Neighbor and far word of twist step k, both modulo the table size.
	assign k_nxt = (k_q == LAST_IDX) ? '0 : k_q + IDX_ONE;
	assign k_far = (k_q < FAR_SPLIT) ? k_q + SHIFT_IDX : k_q - FAR_SPLIT;

	// Twist step for word tw_idx_s1: cur_q is its old value, rd_a the next word,
	// rd_b the far word (already twisted once the far index wraps).
	assign tw_y = (cur_q & MT_UPPER) | (rd_a & MT_LOWER);
	assign tw_w = rd_b ^ (tw_y >> 1) ^ (tw_y[0] ? MT_MATRIX : '0);

	always_comb begin
		ram_req         = '0;
		ram_req.raddr_a = read_idx_q;
		case (state_q)
			ST_FILL: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = k_q;
				ram_req.wdata = fill_x_q;
			end
			ST_TW_PRE: begin
				ram_req.raddr_a = '0;
			end
			ST_TW_RUN, ST_TW_DRAIN: begin
				ram_req.we      = tw_v_s1;
				ram_req.waddr   = tw_idx_s1;
				ram_req.wdata   = tw_w;
				ram_req.raddr_a = k_nxt;
				ram_req.raddr_b = k_far;
			end
			default: begin
				ram_req.raddr_a = read_idx_q;
			end
		endcase
	end

	mtg_ram u_ram (
		.clk  (clk),
		.req  (ram_req),
		.rd_a (rd_a),
		.rd_b (rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			read_idx_q  <= '0;
			filled_q    <= 1'b0;
			seed_q      <= '0;
			k_q         <= '0;
			fill_x_q    <= '0;
			cur_q       <= '0;
			op_draw_q   <= 1'b0;
			tw_v_s1     <= 1'b0;
			tw_idx_s1   <= '0;
			done_q      <= 1'b0;
			value_q     <= '0;
			is_number_q <= 1'b0;
		end else begin
			done_q  <= 1'b0;
			tw_v_s1 <= (state_q == ST_TW_RUN);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (mode)
							MODE_DRAW: begin
								op_draw_q <= 1'b1;
								k_q       <= '0;
								fill_x_q  <= seed_q;
								if (read_idx_q != '0) begin
									// word read is already under way
									state_q <= ST_DRAW_TEMP;
								end else if (filled_q) begin
									state_q <= ST_TW_PRE;
								end else begin
									state_q <= ST_FILL;
								end
							end
							MODE_SEED: begin
								op_draw_q <= 1'b0;
								seed_q    <= seed_eff;
								fill_x_q  <= seed_eff;
								filled_q  <= 1'b0;
								k_q       <= '0;
								state_q   <= ST_FILL;
							end
							MODE_TWIST: begin
								op_draw_q <= 1'b0;
								seed_q    <= seed_eff;
								fill_x_q  <= seed_eff;
								k_q       <= '0;
								state_q   <= filled_q ? ST_TW_PRE : ST_FILL;
							end
							default: begin
								// unused code: acknowledge, touch nothing
								done_q      <= 1'b1;
								value_q     <= '0;
								is_number_q <= 1'b0;
							end
						endcase
					end
				end
				ST_FILL: begin
					fill_x_q <= fill_x_q * MT_FILL_MUL + 32'd1;
					if (k_q == LAST_IDX) begin
						filled_q <= 1'b1;
						k_q      <= '0;
						state_q  <= ST_TW_PRE;
					end else begin
						k_q <= k_q + IDX_ONE;
					end
				end
				ST_TW_PRE: begin
					k_q     <= '0;
					state_q <= ST_TW_RUN;
				end
				ST_TW_RUN: begin
					// word k, read by the previous step or the preload, becomes the old value of its twist step
					cur_q     <= rd_a;
					tw_idx_s1 <= k_q;
					if (k_q == LAST_IDX) begin
						state_q <= ST_TW_DRAIN;
					end else begin
						k_q <= k_q + IDX_ONE;
					end
				end
				ST_TW_DRAIN: begin
					read_idx_q <= IDX_ONE;
					if (op_draw_q) begin
						state_q <= ST_DRAW_RD;
					end else begin
						done_q      <= 1'b1;
						value_q     <= '0;
						is_number_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				ST_DRAW_RD: begin
					state_q <= ST_DRAW_TEMP;
				end
				ST_DRAW_TEMP: begin
					done_q      <= 1'b1;
					value_q     <= mt_temper(rd_a);
					is_number_q <= 1'b1;
					read_idx_q  <= (read_idx_q == LAST_IDX) ? '0 : read_idx_q + IDX_ONE;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign value     = value_q;
	assign is_number = is_number_q;

	`MTG_ASSERT_IMPLY(a_done_idle, clk, arst_n, done, !busy, "result strobe while busy")
	`MTG_ASSERT_IMPLY(a_ack_zero, clk, arst_n, done && !is_number, value == '0, "nonzero ack value")
	`MTG_ASSERT_NEXT(a_fast_draw, clk, arst_n, accept && mode == MODE_DRAW && read_idx_q != '0, ##1 (done && is_number), "draw result late")
	`MTG_ASSERT_IMPLY(a_tw_hazard, clk, arst_n, state_q == ST_TW_RUN && ram_req.we, ram_req.waddr != ram_req.raddr_a && ram_req.waddr != ram_req.raddr_b, "twist write hits a live read")

endmodule

[tb/mtg_test_pkg.sv]
// Command codes shared by the Mersenne twister generator testbench files.
// No dependencies.
`timescale 1ns / 1ps

package mtg_test_pkg;

	typedef enum logic [1:0] {
		MODE_DRAW   = 2'd0,
		MODE_REFILL = 2'd1,
		MODE_TWIST  = 2'd2,
		MODE_NONE   = 2'd3
	} mt_mode_t;

endpackage

[tb/mersenne_twister_checker.sv]
// Scoreboard for the Mersenne twister generator: mirrors the table, predicts each result.
// Depends on mtg_pkg (port widths) and mtg_test_pkg (command codes).
`timescale 1ns / 1ps

module mersenne_twister_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       busy,
	input  logic [1:0]                 mode,
	input  logic [mtg_pkg::WORD_W-1:0] seed_value,
	input  logic                       done,
	input  logic [mtg_pkg::WORD_W-1:0] value,
	input  logic                       is_number,
	output int                         fail_count,
	output int                         pending_results
);
	import mtg_test_pkg::*;

	localparam int          TABLE_WORDS = 624;
	localparam int          FAR_OFFSET  = 397;
	localparam logic [31:0] TWIST_XOR   = 32'h9908_b0df;
	localparam logic [31:0] TEMPER_B    = 32'h9d2c_5680;
	localparam logic [31:0] TEMPER_C    = 32'hefc6_0000;
	localparam logic [31:0] FILL_MUL    = 32'd69069;
	localparam logic [31:0] TOP_BIT     = 32'h8000_0000;
	localparam logic [31:0] LOW_BITS    = 32'h7fff_ffff;

	typedef struct {
		logic [31:0] word;
		logic        is_num;
	} gen_result_t;

	gen_result_t awaited_results[$];

	logic [31:0] table_words [TABLE_WORDS];
	int unsigned next_index;
	bit          table_ready;
	logic [31:0] seed_reg;

	function automatic logic [31:0] temper_word(input logic [31:0] raw);
		logic [31:0] y;
		y = raw;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	// Fill from the stored seed when the table is empty, then twist in place.
	function automatic void refresh_table(input logic [31:0] seed_in);
		logic [31:0] mixed;
		if (seed_in != 32'd0)
			seed_reg = seed_in;
		if (!table_ready) begin
			table_words[0] = seed_reg;
			for (int i = 1; i < TABLE_WORDS; i++)
				table_words[i] = FILL_MUL * table_words[i-1] + 32'd1;
			table_ready = 1'b1;
		end
		for (int i = 0; i < TABLE_WORDS; i++) begin
			mixed = (table_words[i] & TOP_BIT) | (table_words[(i + 1) % TABLE_WORDS] & LOW_BITS);
			table_words[i] = table_words[(i + FAR_OFFSET) % TABLE_WORDS] ^ (mixed >> 1)
				^ (mixed[0] ? TWIST_XOR : 32'd0);
		end
		next_index = 1;
	endfunction

	function automatic gen_result_t predict_item(input mt_mode_t m, input logic [31:0] s);
		gen_result_t r;
		r.word   = 32'd0;
		r.is_num = 1'b0;
		case (m)
			MODE_DRAW: begin
				if (next_index >= TABLE_WORDS)
					next_index = 0;
				if (next_index == 0)
					refresh_table(32'd0);
				r.word     = temper_word(table_words[next_index]);
				r.is_num   = 1'b1;
				next_index = (next_index + 1) % TABLE_WORDS;
			end
			MODE_REFILL: begin
				table_ready = 1'b0;
				refresh_table(s);
			end
			MODE_TWIST: refresh_table(s);
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		gen_result_t want;
		if (!arst_n) begin
			awaited_results.delete();
			next_index      = 0;
			table_ready     = 1'b0;
			seed_reg        = 32'd0;
			fail_count      = 0;
			pending_results = 0;
		end else begin
			// Results leave before new items join, so a same-edge pair keeps its order.
			if (done) begin
				if (awaited_results.size() == 0) begin
					$error("result with no item waiting: value %h is_number %b",
						value, is_number);
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					if (value !== want.word) begin
						$error("value: expected %h, actual %h", want.word, value);
						fail_count++;
					end
					if (is_number !== want.is_num) begin
						$error("is_number: expected %b, actual %b", want.is_num, is_number);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				awaited_results.push_back(predict_item(mt_mode_t'(mode), seed_value));
			pending_results = awaited_results.size();
		end
	end

endmodule

[tb/mersenne_twister_generator_test.sv]
// Testbench top for the Mersenne twister generator: clock, reset, command stimulus, verdict.
// Depends on mtg_pkg, mtg_test_pkg, mersenne_twister_checker and the generator RTL.
`timescale 1ns / 1ps

module mersenne_twister_generator_test;
	import mtg_test_pkg::*;

	// Items that change state (draws, refills, twists) before the random part stops.
	localparam int ITEM_TARGET = 1100;
	// A refill runs fill plus twist; the limit allows several times the length of one.
	localparam int QUIET_LIMIT = 6000;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic [1:0]                 mode;
	logic [mtg_pkg::WORD_W-1:0] seed_value;
	logic                       done;
	logic [mtg_pkg::WORD_W-1:0] value;
	logic                       is_number;

	int fail_count;
	int pending_results;
	int item_count;
	int quiet_cycles = 0;

	always #1 clk = ~clk;

	mersenne_twister_generator u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.seed_value (seed_value),
		.done       (done),
		.value      (value),
		.is_number  (is_number)
	);

	mersenne_twister_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.mode            (mode),
		.seed_value      (seed_value),
		.done            (done),
		.value           (value),
		.is_number       (is_number),
		.fail_count      (fail_count),
		.pending_results (pending_results)
	);

	// Watchdog: end the run if neither an item nor a result moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Present one item and hold it until the block takes it. Before that, idle for a
	// random few cycles with junk on the fields, except in a quiet stretch mid-run.
	task automatic issue(input mt_mode_t m, input logic [31:0] s);
		bit allow_gaps;
		allow_gaps = !(item_count >= 150 && item_count < 450);
		if (allow_gaps) begin
			while ($urandom_range(99) < 9) begin
				start      <= 1'b0;
				mode       <= 2'($urandom);
				seed_value <= $urandom;
				@(posedge clk);
			end
		end
		start      <= 1'b1;
		mode       <= m;
		seed_value <= s;
		do @(posedge clk); while (busy);
		if (m != MODE_NONE)
			item_count++;
	endtask

	initial begin : stimulus
		int burst;
		bit first_burst;
		mt_mode_t ctrl;
		start        <= 1'b0;
		mode         <= MODE_DRAW;
		seed_value   <= '0;
		arst_n       <= 1'b0;
		item_count   = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: unused mode first, then a draw on the never-filled table with the
		// stored seed still zero; the seed field of a draw must be ignored.
		issue(MODE_NONE, 32'hffff_ffff);
		issue(MODE_DRAW, 32'hffff_ffff);
		issue(MODE_DRAW, 32'h0000_0000);
		// Twist only with a zero seed: keep the stored seed, no refill.
		issue(MODE_TWIST, 32'h0000_0000);
		issue(MODE_DRAW, 32'h5555_5555);
		// Refill from the all-ones seed, then from seed one via a twist that only stores it.
		issue(MODE_REFILL, 32'hffff_ffff);
		issue(MODE_DRAW, 32'haaaa_aaaa);
		issue(MODE_DRAW, 32'h0000_0000);
		issue(MODE_TWIST, 32'h0000_0001);
		issue(MODE_DRAW, 32'h0000_0000);
		// Refill with zero on the field: reuse the stored seed of one.
		issue(MODE_REFILL, 32'h0000_0000);
		issue(MODE_DRAW, 32'h0000_0000);
		issue(MODE_REFILL, 32'h8000_0000);
		issue(MODE_DRAW, 32'h0000_0000);
		issue(MODE_NONE, 32'h0000_0000);
		issue(MODE_DRAW, 32'h0000_0000);
		issue(MODE_TWIST, 32'haaaa_aaaa);
		issue(MODE_DRAW, 32'h5555_5555);
		issue(MODE_NONE, 32'h5555_5555);
		issue(MODE_DRAW, 32'hffff_ffff);

		// Random: a refill or twist followed by a burst of draws. The first burst runs past
		// the end of the table so the draw-time twist and the index wrap are hit; later
		// bursts are mostly short, now and then long enough to wrap again.
		first_burst = 1'b1;
		while (item_count < ITEM_TARGET) begin
			ctrl = ($urandom_range(1) == 0) ? MODE_REFILL : MODE_TWIST;
			issue(ctrl, ($urandom_range(3) == 0) ? 32'd0 : $urandom);
			if (first_burst)
				burst = 700;
			else if ($urandom_range(9) == 0)
				burst = $urandom_range(700, 600);
			else
				burst = $urandom_range(40);
			// Trim the last burst so the run stays near the item target.
			if (burst > ITEM_TARGET - item_count)
				burst = ITEM_TARGET - item_count;
			first_burst = 1'b0;
			repeat (burst) begin
				if ($urandom_range(29) == 0)
					issue(MODE_NONE, $urandom);
				issue(MODE_DRAW, $urandom);
			end
		end
		start <= 1'b0;
		// Let the checker log the last item before polling its queue.
		@(posedge clk);

		// Drain: the watchdog covers a result that never comes.
		while (pending_results != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
